@@ hw/rtl/c8_pkg.sv @@
// Shared constants, command codes, sequencer codes and types of the CHIP-8 executor.
package c8_pkg;

    localparam int MEM_BYTES   = 4096;
    localparam int ADDR_W      = $clog2(MEM_BYTES);
    localparam int SCREEN_W    = 64;
    localparam int SCREEN_H    = 32;
    localparam int ROW_W       = $clog2(SCREEN_H);
    localparam int STACK_DEPTH = 16;
    localparam int STK_W       = $clog2(STACK_DEPTH);
    localparam int SP_W        = $clog2(STACK_DEPTH + 1);
    localparam int CNT_W       = ADDR_W;
    localparam int FONT_BYTES  = 80;
    localparam int FONT_W      = $clog2(FONT_BYTES);

    localparam logic [ADDR_W-1:0] FONT_BASE = ADDR_W'(12'h050);
    localparam logic [ADDR_W-1:0] PC_START  = ADDR_W'(12'h200);

    // input commands
    localparam logic [2:0] CMD_EXEC    = 3'd0;
    localparam logic [2:0] CMD_KEY     = 3'd1;
    localparam logic [2:0] CMD_TICK    = 3'd2;
    localparam logic [2:0] CMD_MEM_WR  = 3'd3;
    localparam logic [2:0] CMD_MEM_RD  = 3'd4;
    localparam logic [2:0] CMD_ROW_RD  = 3'd5;
    localparam logic [2:0] CMD_REG_RD  = 3'd6;

    // register read selectors beyond V0..VF
    localparam logic [11:0] REG_DELAY = 12'd16;
    localparam logic [11:0] REG_SOUND = 12'd17;
    localparam logic [11:0] REG_SP    = 12'd18;

    // configuration register indexes
    localparam logic [1:0] CFG_SHIFT_VY  = 2'd0;
    localparam logic [1:0] CFG_JUMP_VX   = 2'd1;
    localparam logic [1:0] CFG_BLOCK_IDX = 2'd2;

    // datapath micro-operations
    localparam logic [4:0] U_NOP  = 5'd0;
    localparam logic [4:0] U_CLR  = 5'd1;
    localparam logic [4:0] U_LOAD = 5'd2;
    localparam logic [4:0] U_RVX  = 5'd3;
    localparam logic [4:0] U_RVY  = 5'd4;
    localparam logic [4:0] U_CAPY = 5'd5;
    localparam logic [4:0] U_EXEC = 5'd6;
    localparam logic [4:0] U_WVF  = 5'd7;
    localparam logic [4:0] U_RET  = 5'd8;
    localparam logic [4:0] U_CLS  = 5'd9;
    localparam logic [4:0] U_DRD  = 5'd10;
    localparam logic [4:0] U_DWR  = 5'd11;
    localparam logic [4:0] U_BCD  = 5'd12;
    localparam logic [4:0] U_SRD  = 5'd13;
    localparam logic [4:0] U_SWR  = 5'd14;
    localparam logic [4:0] U_LRD  = 5'd15;
    localparam logic [4:0] U_LWR  = 5'd16;
    localparam logic [4:0] U_CAP  = 5'd17;
    localparam logic [4:0] U_DONE = 5'd18;

    // follow-up work an item needs after its execute step
    localparam logic [3:0] CL_NONE  = 4'd0;
    localparam logic [3:0] CL_FLAG  = 4'd1;
    localparam logic [3:0] CL_RET   = 4'd2;
    localparam logic [3:0] CL_CLS   = 4'd3;
    localparam logic [3:0] CL_DRAW  = 4'd4;
    localparam logic [3:0] CL_BCD   = 4'd5;
    localparam logic [3:0] CL_STORE = 4'd6;
    localparam logic [3:0] CL_LOAD  = 4'd7;
    localparam logic [3:0] CL_READ  = 4'd8;

    typedef struct packed {
        logic [4:0]       uop;
        logic [CNT_W-1:0] cnt;
    } t_dp_cmd;

    typedef struct packed {
        logic [3:0] cls;
        logic       draw_stop;
        logic       last_reg;
        logic       out_free;
    } t_dp_stat;

    localparam logic [7:0] FONT [FONT_BYTES] = '{
        8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
        8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
        8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
        8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
        8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
        8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
        8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
        8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
    };

endpackage

@@ hw/rtl/c8_in_if.sv @@
// Input channel of the CHIP-8 executor: handshake and item fields.
interface c8_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  cmd;
    logic [15:0] opcode;
    logic [15:0] key_state;
    logic [7:0]  random_byte;
    logic [3:0]  key_code;
    logic [11:0] address;
    logic [7:0]  write_data;

    modport source (output valid, cmd, opcode, key_state, random_byte, key_code, address,
                    write_data, input ready);
    modport sink (input valid, cmd, opcode, key_state, random_byte, key_code, address,
                  write_data, output ready);
endinterface

@@ hw/rtl/c8_out_if.sv @@
// Result channel of the CHIP-8 executor: handshake and result fields.
interface c8_out_if;
    logic        valid;
    logic        ready;
    logic [11:0] next_pc;
    logic [15:0] index_value;
    logic [63:0] read_data;
    logic        awaiting_key;
    logic        sound_active;

    modport source (output valid, next_pc, index_value, read_data, awaiting_key,
                    sound_active, input ready);
    modport sink (input valid, next_pc, index_value, read_data, awaiting_key,
                  sound_active, output ready);
endinterface

@@ hw/rtl/c8_ram.sv @@
// Generic simple dual-port RAM with registered read.
module c8_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

@@ hw/rtl/c8_datapath.sv @@
// Datapath: architectural registers, memories, ALU, sprite unit and result register.
module c8_datapath (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  c8_pkg::t_dp_cmd      i_cmd,
    output c8_pkg::t_dp_stat     o_stat,
    input  logic                 i_cfg_we,
    input  logic [1:0]           i_cfg_idx,
    input  logic [0:0]           i_cfg_wdata,
    input  logic [2:0]           i_cmd_f,
    input  logic [15:0]          i_opcode,
    input  logic [15:0]          i_key_state,
    input  logic [7:0]           i_random_byte,
    input  logic [3:0]           i_key_code,
    input  logic [11:0]          i_address,
    input  logic [7:0]           i_write_data,
    input  logic                 i_out_ready,
    output logic                 o_out_valid,
    output logic [11:0]          o_next_pc,
    output logic [15:0]          o_index_value,
    output logic [63:0]          o_read_data,
    output logic                 o_awaiting_key,
    output logic                 o_sound_active
);
    import c8_pkg::*;

    // latched item
    logic [2:0]  r_cmd;
    logic [15:0] r_op;
    logic [15:0] r_keys;
    logic [7:0]  r_rnd;
    logic [3:0]  r_kc;
    logic [11:0] r_addr;
    logic [7:0]  r_wd;

    // architectural state
    logic [ADDR_W-1:0] r_pc, n_pc;
    logic [15:0]       r_idx, n_idx;
    logic [SP_W-1:0]   r_sp, n_sp;
    logic [7:0]        r_dt, n_dt;
    logic [7:0]        r_st, n_st;
    logic              r_wait, n_wait;
    logic [3:0]        r_wtgt, n_wtgt;
    logic              r_cfg_shift, r_cfg_jump, r_cfg_block;

    // working registers
    logic [7:0]  r_vx, n_vx;
    logic [7:0]  r_vy, n_vy;
    logic        r_flag, n_flag;
    logic        r_hit, n_hit;
    logic [63:0] r_rd, n_rd;

    // result register
    logic        r_ov;
    logic [11:0] r_o_pc;
    logic [15:0] r_o_idx;
    logic [63:0] r_o_rd;
    logic        r_o_wait;
    logic        r_o_snd;

    // memory ports
    logic              dr_we;
    logic [3:0]        dr_wa, dr_ra;
    logic [7:0]        dr_wd, dr_q;
    logic              m_we;
    logic [ADDR_W-1:0] m_wa, m_ra;
    logic [7:0]        m_wd, m_q;
    logic              f_we;
    logic [ROW_W-1:0]  f_wa, f_ra;
    logic [63:0]       f_wd, f_q;
    logic              s_we;
    logic [STK_W-1:0]  s_wa, s_ra;
    logic [11:0]       s_wd, s_q;

    logic [3:0]  hi, x, y, nib;
    logic [7:0]  kk;
    logic [11:0] nnn;
    logic [ADDR_W-1:0] pc2, pc4, idx_cnt, font_off;
    logic [3:0]  cls;
    logic [8:0]  sum9;
    logic [7:0]  alu_res;
    logic        alu_flag;
    logic [7:0]  shsrc;
    logic        key_hit;

    logic [5:0]       cx;
    logic [ROW_W-1:0] cy;
    logic [ROW_W:0]   row_sum;
    logic [63:0]      spr_base, spr_pat;
    logic [127:0]     spr_dbl;
    logic             draw_stop;

    logic [1:0]  bcd_h;
    logic [6:0]  bcd_rem;
    logic [14:0] bcd_prod;
    logic [3:0]  bcd_t, bcd_o;
    logic [7:0]  bcd_digit;

    assign hi  = r_op[15:12];
    assign x   = r_op[11:8];
    assign y   = r_op[7:4];
    assign nib = r_op[3:0];
    assign kk  = r_op[7:0];
    assign nnn = r_op[11:0];

    assign pc2      = r_pc + ADDR_W'(2);
    assign pc4      = r_pc + ADDR_W'(4);
    assign idx_cnt  = r_idx[ADDR_W-1:0] + i_cmd.cnt[ADDR_W-1:0];
    assign font_off = ADDR_W'(i_cmd.cnt - CNT_W'(FONT_BASE));
    assign key_hit  = r_keys[r_vx[3:0]];

    // ALU for the 8xyN group
    assign sum9  = {1'b0, r_vx} + {1'b0, r_vy};
    assign shsrc = r_cfg_shift ? r_vy : r_vx;
    always_comb begin
        alu_res  = r_vy;
        alu_flag = 1'b0;
        case (nib)
            4'h1: alu_res = r_vx | r_vy;
            4'h2: alu_res = r_vx & r_vy;
            4'h3: alu_res = r_vx ^ r_vy;
            4'h4: begin
                alu_res  = sum9[7:0];
                alu_flag = sum9[8];
            end
            4'h5: begin
                alu_res  = r_vx - r_vy;
                alu_flag = (r_vx >= r_vy);
            end
            4'h6: begin
                alu_res  = {1'b0, shsrc[7:1]};
                alu_flag = shsrc[0];
            end
            4'h7: begin
                alu_res  = r_vy - r_vx;
                alu_flag = (r_vy >= r_vx);
            end
            4'hE: begin
                alu_res  = {shsrc[6:0], 1'b0};
                alu_flag = shsrc[7];
            end
            default: alu_res = r_vy;
        endcase
    end

    // sprite row: rotate the byte into place so pixels wrap across the right edge
    assign cx        = r_vx[5:0];
    assign cy        = r_vy[ROW_W-1:0];
    assign row_sum   = {1'b0, cy} + i_cmd.cnt[ROW_W:0];
    assign spr_base  = {m_q, 56'd0};
    assign spr_dbl   = {spr_base, spr_base} >> cx;
    assign spr_pat   = spr_dbl[63:0];
    assign draw_stop = (i_cmd.cnt >= CNT_W'(nib)) || (row_sum >= (ROW_W+1)'(SCREEN_H));

    // decimal digits of Vx; tens via multiply by 205/2048
    always_comb begin
        if (r_vx >= 8'd200) begin
            bcd_h = 2'd2;
        end else if (r_vx >= 8'd100) begin
            bcd_h = 2'd1;
        end else begin
            bcd_h = 2'd0;
        end
        bcd_rem  = 7'(r_vx - 8'(bcd_h) * 8'd100);
        bcd_prod = 15'(bcd_rem) * 15'd205;
        bcd_t    = bcd_prod[14:11];
        bcd_o    = 4'(bcd_rem - 7'(bcd_t) * 7'd10);
        case (i_cmd.cnt[1:0])
            2'd0:    bcd_digit = {6'd0, bcd_h};
            2'd1:    bcd_digit = {4'd0, bcd_t};
            default: bcd_digit = {4'd0, bcd_o};
        endcase
    end

    // follow-up class of the latched item
    always_comb begin
        cls = CL_NONE;
        case (r_cmd)
            CMD_EXEC: begin
                if (!r_wait) begin
                    case (hi)
                        4'h0: begin
                            if (kk == 8'hE0) begin
                                cls = CL_CLS;
                            end else if (r_op == 16'h00EE && r_sp != '0) begin
                                cls = CL_RET;
                            end
                        end
                        4'h8: begin
                            case (nib)
                                4'h1, 4'h2, 4'h3, 4'h4, 4'h5, 4'h6, 4'h7, 4'hE: cls = CL_FLAG;
                                default: cls = CL_NONE;
                            endcase
                        end
                        4'hD: cls = CL_DRAW;
                        4'hF: begin
                            case (kk)
                                8'h33:   cls = CL_BCD;
                                8'h55:   cls = CL_STORE;
                                8'h65:   cls = CL_LOAD;
                                default: cls = CL_NONE;
                            endcase
                        end
                        default: cls = CL_NONE;
                    endcase
                end
            end
            CMD_MEM_RD, CMD_ROW_RD: cls = CL_READ;
            default: cls = CL_NONE;
        endcase
    end

    assign o_stat.cls       = cls;
    assign o_stat.draw_stop = draw_stop;
    assign o_stat.last_reg  = (i_cmd.cnt[3:0] == x);
    assign o_stat.out_free  = !r_ov || i_out_ready;

    always_comb begin
        n_pc   = r_pc;
        n_idx  = r_idx;
        n_sp   = r_sp;
        n_dt   = r_dt;
        n_st   = r_st;
        n_wait = r_wait;
        n_wtgt = r_wtgt;
        n_vx   = r_vx;
        n_vy   = r_vy;
        n_flag = r_flag;
        n_hit  = r_hit;
        n_rd   = r_rd;
        dr_we  = 1'b0;
        dr_wa  = x;
        dr_wd  = 8'd0;
        dr_ra  = x;
        m_we   = 1'b0;
        m_wa   = idx_cnt;
        m_wd   = 8'd0;
        m_ra   = idx_cnt;
        f_we   = 1'b0;
        f_wa   = row_sum[ROW_W-1:0];
        f_wd   = 64'd0;
        f_ra   = row_sum[ROW_W-1:0];
        s_we   = 1'b0;
        s_wa   = r_sp[STK_W-1:0];
        s_wd   = pc2;
        s_ra   = STK_W'(r_sp - SP_W'(1));

        unique case (i_cmd.uop)
            U_CLR: begin
                // reset sweep: font image in memory, rest of memory, frame rows and V registers zero
                m_we  = 1'b1;
                m_wa  = i_cmd.cnt[ADDR_W-1:0];
                m_wd  = (i_cmd.cnt >= CNT_W'(FONT_BASE) &&
                         i_cmd.cnt < CNT_W'(FONT_BASE) + CNT_W'(FONT_BYTES))
                        ? FONT[font_off[FONT_W-1:0]] : 8'd0;
                f_we  = (i_cmd.cnt < CNT_W'(SCREEN_H));
                f_wa  = i_cmd.cnt[ROW_W-1:0];
                dr_we = (i_cmd.cnt < CNT_W'(16));
                dr_wa = i_cmd.cnt[3:0];
            end
            U_RVX: begin
                if (r_cmd == CMD_REG_RD) begin
                    dr_ra = r_addr[3:0];
                end else if (hi == 4'hB && !r_cfg_jump) begin
                    dr_ra = 4'd0;
                end else begin
                    dr_ra = x;
                end
            end
            U_RVY: begin
                dr_ra = y;
                n_vx  = dr_q;
            end
            U_CAPY: n_vy = dr_q;
            U_EXEC: begin
                n_rd  = 64'd0;
                n_hit = 1'b0;
                case (r_cmd)
                    CMD_EXEC: begin
                        if (!r_wait) begin
                            n_pc = pc2;
                            case (hi)
                                4'h0: begin
                                    if (cls == CL_RET) begin
                                        n_sp = r_sp - SP_W'(1);
                                    end
                                end
                                4'h1: n_pc = nnn;
                                4'h2: begin
                                    if (r_sp < SP_W'(STACK_DEPTH)) begin
                                        s_we = 1'b1;
                                        n_sp = r_sp + SP_W'(1);
                                        n_pc = nnn;
                                    end
                                end
                                4'h3: if (r_vx == kk) n_pc = pc4;
                                4'h4: if (r_vx != kk) n_pc = pc4;
                                4'h5: if (nib == 4'h0 && r_vx == r_vy) n_pc = pc4;
                                4'h6: begin
                                    dr_we = 1'b1;
                                    dr_wd = kk;
                                end
                                4'h7: begin
                                    dr_we = 1'b1;
                                    dr_wd = r_vx + kk;
                                end
                                4'h8: begin
                                    if (cls == CL_FLAG || nib == 4'h0) begin
                                        dr_we = 1'b1;
                                        dr_wd = alu_res;
                                    end
                                    n_flag = alu_flag;
                                end
                                4'h9: if (nib == 4'h0 && r_vx != r_vy) n_pc = pc4;
                                4'hA: n_idx = {4'd0, nnn};
                                4'hB: n_pc = nnn + {4'd0, r_vx};
                                4'hC: begin
                                    dr_we = 1'b1;
                                    dr_wd = r_rnd & kk;
                                end
                                4'hE: begin
                                    if ((kk == 8'h9E && key_hit) || (kk == 8'hA1 && !key_hit)) begin
                                        n_pc = pc4;
                                    end
                                end
                                4'hF: begin
                                    case (kk)
                                        8'h07: begin
                                            dr_we = 1'b1;
                                            dr_wd = r_dt;
                                        end
                                        8'h0A: begin
                                            n_wait = 1'b1;
                                            n_wtgt = x;
                                            n_pc   = r_pc;
                                        end
                                        8'h15: n_dt = r_vx;
                                        8'h18: n_st = r_vx;
                                        8'h1E: n_idx = r_idx + {8'd0, r_vx};
                                        8'h29: n_idx = 16'(FONT_BASE) + 16'(r_vx[3:0]) * 16'd5;
                                        default: n_pc = pc2;
                                    endcase
                                end
                                default: n_pc = pc2;
                            endcase
                        end
                    end
                    CMD_KEY: begin
                        if (r_wait) begin
                            dr_we  = 1'b1;
                            dr_wa  = r_wtgt;
                            dr_wd  = {4'd0, r_kc};
                            n_wait = 1'b0;
                            n_pc   = pc2;
                        end
                    end
                    CMD_TICK: begin
                        if (r_dt != 8'd0) n_dt = r_dt - 8'd1;
                        if (r_st != 8'd0) n_st = r_st - 8'd1;
                    end
                    CMD_MEM_WR: begin
                        m_we = 1'b1;
                        m_wa = r_addr[ADDR_W-1:0];
                        m_wd = r_wd;
                    end
                    CMD_MEM_RD: m_ra = r_addr[ADDR_W-1:0];
                    CMD_ROW_RD: f_ra = r_addr[ROW_W-1:0];
                    CMD_REG_RD: begin
                        if (r_addr < 12'd16) begin
                            n_rd = {56'd0, r_vx};
                        end else if (r_addr == REG_DELAY) begin
                            n_rd = {56'd0, r_dt};
                        end else if (r_addr == REG_SOUND) begin
                            n_rd = {56'd0, r_st};
                        end else if (r_addr == REG_SP) begin
                            n_rd = 64'(r_sp);
                        end
                    end
                    default: n_rd = 64'd0;
                endcase
            end
            U_WVF: begin
                dr_we = 1'b1;
                dr_wa = 4'hF;
                dr_wd = {7'd0, r_flag};
            end
            U_RET: n_pc = s_q;
            U_CLS: begin
                f_we = 1'b1;
                f_wa = i_cmd.cnt[ROW_W-1:0];
            end
            U_DRD: begin
                // at the end of the sprite the collision result becomes the flag
                if (draw_stop) begin
                    n_flag = r_hit;
                end
            end
            U_DWR: begin
                f_we  = 1'b1;
                f_wd  = f_q ^ spr_pat;
                n_hit = r_hit | (|(f_q & spr_pat));
            end
            U_BCD: begin
                m_we = 1'b1;
                m_wd = bcd_digit;
            end
            U_SRD: dr_ra = i_cmd.cnt[3:0];
            U_SWR: begin
                m_we = 1'b1;
                m_wd = dr_q;
                if (i_cmd.cnt[3:0] == x && r_cfg_block) begin
                    n_idx = r_idx + 16'(x) + 16'd1;
                end
            end
            U_LRD: m_ra = idx_cnt;
            U_LWR: begin
                dr_we = 1'b1;
                dr_wa = i_cmd.cnt[3:0];
                dr_wd = m_q;
                if (i_cmd.cnt[3:0] == x && r_cfg_block) begin
                    n_idx = r_idx + 16'(x) + 16'd1;
                end
            end
            U_CAP: begin
                if (r_cmd == CMD_MEM_RD) begin
                    n_rd = {56'd0, m_q};
                end else if (r_addr < 12'(SCREEN_H)) begin
                    n_rd = f_q;
                end else begin
                    n_rd = 64'd0;
                end
            end
            default: n_rd = r_rd;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc        <= PC_START;
            r_idx       <= 16'd0;
            r_sp        <= '0;
            r_dt        <= 8'd0;
            r_st        <= 8'd0;
            r_wait      <= 1'b0;
            r_wtgt      <= 4'd0;
            r_cfg_shift <= 1'b0;
            r_cfg_jump  <= 1'b0;
            r_cfg_block <= 1'b0;
            r_ov        <= 1'b0;
        end else begin
            r_pc   <= n_pc;
            r_idx  <= n_idx;
            r_sp   <= n_sp;
            r_dt   <= n_dt;
            r_st   <= n_st;
            r_wait <= n_wait;
            r_wtgt <= n_wtgt;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_SHIFT_VY:  r_cfg_shift <= i_cfg_wdata[0];
                    CFG_JUMP_VX:   r_cfg_jump  <= i_cfg_wdata[0];
                    CFG_BLOCK_IDX: r_cfg_block <= i_cfg_wdata[0];
                    default:       r_cfg_block <= r_cfg_block;
                endcase
            end
            if (i_cmd.uop == U_DONE) begin
                r_ov <= 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_vx   <= n_vx;
        r_vy   <= n_vy;
        r_flag <= n_flag;
        r_hit  <= n_hit;
        r_rd   <= n_rd;
        if (i_cmd.uop == U_LOAD) begin
            r_cmd  <= i_cmd_f;
            r_op   <= i_opcode;
            r_keys <= i_key_state;
            r_rnd  <= i_random_byte;
            r_kc   <= i_key_code;
            r_addr <= i_address;
            r_wd   <= i_write_data;
        end
        if (i_cmd.uop == U_DONE) begin
            r_o_pc   <= r_pc;
            r_o_idx  <= r_idx;
            r_o_rd   <= r_rd;
            r_o_wait <= r_wait;
            r_o_snd  <= (r_st != 8'd0);
        end
    end

    assign o_out_valid    = r_ov;
    assign o_next_pc      = r_o_pc;
    assign o_index_value  = r_o_idx;
    assign o_read_data    = r_o_rd;
    assign o_awaiting_key = r_o_wait;
    assign o_sound_active = r_o_snd;

    c8_ram #(.WIDTH(8), .DEPTH(16)) u_vregs (
        .i_clk(i_clk), .i_we(dr_we), .i_waddr(dr_wa), .i_wdata(dr_wd),
        .i_raddr(dr_ra), .o_rdata(dr_q)
    );

    c8_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_mem (
        .i_clk(i_clk), .i_we(m_we), .i_waddr(m_wa), .i_wdata(m_wd),
        .i_raddr(m_ra), .o_rdata(m_q)
    );

    c8_ram #(.WIDTH(SCREEN_W), .DEPTH(SCREEN_H)) u_frame (
        .i_clk(i_clk), .i_we(f_we), .i_waddr(f_wa), .i_wdata(f_wd),
        .i_raddr(f_ra), .o_rdata(f_q)
    );

    c8_ram #(.WIDTH(12), .DEPTH(STACK_DEPTH)) u_stack (
        .i_clk(i_clk), .i_we(s_we), .i_waddr(s_wa), .i_wdata(s_wd),
        .i_raddr(s_ra), .o_rdata(s_q)
    );
endmodule

@@ hw/rtl/c8_ctrl.sv @@
// Controller: sequences the datapath through each item and the reset sweep.
module c8_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  c8_pkg::t_dp_stat  i_stat,
    output c8_pkg::t_dp_cmd   o_cmd
);
    import c8_pkg::*;

    localparam logic [4:0] S_CLR  = 5'd0;
    localparam logic [4:0] S_IDLE = 5'd1;
    localparam logic [4:0] S_RVX  = 5'd2;
    localparam logic [4:0] S_RVY  = 5'd3;
    localparam logic [4:0] S_CAPY = 5'd4;
    localparam logic [4:0] S_EXEC = 5'd5;
    localparam logic [4:0] S_WVF  = 5'd6;
    localparam logic [4:0] S_RET  = 5'd7;
    localparam logic [4:0] S_CLS  = 5'd8;
    localparam logic [4:0] S_DRD  = 5'd9;
    localparam logic [4:0] S_DWR  = 5'd10;
    localparam logic [4:0] S_BCD  = 5'd11;
    localparam logic [4:0] S_SRD  = 5'd12;
    localparam logic [4:0] S_SWR  = 5'd13;
    localparam logic [4:0] S_LRD  = 5'd14;
    localparam logic [4:0] S_LWR  = 5'd15;
    localparam logic [4:0] S_CAP  = 5'd16;
    localparam logic [4:0] S_FIN  = 5'd17;

    logic [4:0]       r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [4:0]       uop;

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        uop        = U_NOP;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_CLR: begin
                uop   = U_CLR;
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(MEM_BYTES - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    uop     = U_LOAD;
                    n_state = S_RVX;
                end
            end
            S_RVX: begin
                uop     = U_RVX;
                n_state = S_RVY;
            end
            S_RVY: begin
                uop     = U_RVY;
                n_state = S_CAPY;
            end
            S_CAPY: begin
                uop     = U_CAPY;
                n_state = S_EXEC;
            end
            S_EXEC: begin
                uop   = U_EXEC;
                n_cnt = '0;
                case (i_stat.cls)
                    CL_FLAG:  n_state = S_WVF;
                    CL_RET:   n_state = S_RET;
                    CL_CLS:   n_state = S_CLS;
                    CL_DRAW:  n_state = S_DRD;
                    CL_BCD:   n_state = S_BCD;
                    CL_STORE: n_state = S_SRD;
                    CL_LOAD:  n_state = S_LRD;
                    CL_READ:  n_state = S_CAP;
                    default:  n_state = S_FIN;
                endcase
            end
            S_WVF: begin
                uop     = U_WVF;
                n_state = S_FIN;
            end
            S_RET: begin
                uop     = U_RET;
                n_state = S_FIN;
            end
            S_CLS: begin
                uop   = U_CLS;
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(SCREEN_H - 1)) begin
                    n_state = S_FIN;
                end
            end
            S_DRD: begin
                uop     = U_DRD;
                n_state = i_stat.draw_stop ? S_WVF : S_DWR;
            end
            S_DWR: begin
                uop     = U_DWR;
                n_cnt   = r_cnt + CNT_W'(1);
                n_state = S_DRD;
            end
            S_BCD: begin
                uop   = U_BCD;
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(2)) begin
                    n_state = S_FIN;
                end
            end
            S_SRD: begin
                uop     = U_SRD;
                n_state = S_SWR;
            end
            S_SWR: begin
                uop     = U_SWR;
                n_cnt   = r_cnt + CNT_W'(1);
                n_state = i_stat.last_reg ? S_FIN : S_SRD;
            end
            S_LRD: begin
                uop     = U_LRD;
                n_state = S_LWR;
            end
            S_LWR: begin
                uop     = U_LWR;
                n_cnt   = r_cnt + CNT_W'(1);
                n_state = i_stat.last_reg ? S_FIN : S_LRD;
            end
            S_CAP: begin
                uop     = U_CAP;
                n_state = S_FIN;
            end
            S_FIN: begin
                // hold until the result register is free
                if (i_stat.out_free) begin
                    uop     = U_DONE;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_cmd.uop = uop;
    assign o_cmd.cnt = r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end
endmodule

@@ hw/rtl/chip8_instruction_executor_top.sv @@
// CHIP-8 executor: one command per input beat, one result beat per command. After reset the
// block sweeps memory, frame and V registers (font loaded at 0x50) and takes no beat
// meanwhile. An item then holds the block through its steps (accept, three operand-read steps,
// execute, finish) plus its follow-up: a VF write or a return, a screen clear of all 32 rows,
// a read and a write per sprite row drawn (then a last row check and the VF write), three BCD
// digit writes, a read and a write per register moved by Fx55/Fx65, or a capture step for a
// memory or frame-row read. The register file and memory give one registered read per cycle.
// A finished result waits in an output register while the next beat is accepted; the finish
// step holds while that register is full and not being taken.
module chip8_instruction_executor_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    c8_in_if.sink       i_in,
    c8_out_if.source    o_out,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [0:0]  i_cfg_wdata
);
    import c8_pkg::*;

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    c8_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd)
    );

    c8_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (dp_cmd),
        .o_stat         (dp_stat),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_cmd_f        (i_in.cmd),
        .i_opcode       (i_in.opcode),
        .i_key_state    (i_in.key_state),
        .i_random_byte  (i_in.random_byte),
        .i_key_code     (i_in.key_code),
        .i_address      (i_in.address),
        .i_write_data   (i_in.write_data),
        .i_out_ready    (o_out.ready),
        .o_out_valid    (o_out.valid),
        .o_next_pc      (o_out.next_pc),
        .o_index_value  (o_out.index_value),
        .o_read_data    (o_out.read_data),
        .o_awaiting_key (o_out.awaiting_key),
        .o_sound_active (o_out.sound_active)
    );
endmodule

@@ tb/chip8_instruction_executor_top_tb.sv @@
// Self-checking testbench of the CHIP-8 executor: directed table, then random programs.
module chip8_instruction_executor_top_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import c8_pkg::*;

    localparam int LIMIT_CYCLES = 500000;
    localparam int RAND_ITEMS   = 1500;
    localparam int PHASES       = 4;
    localparam int DRAIN_CYCLES = 60;

    // instruction groups (top nibble)
    localparam logic [3:0] OP_SYS = 4'h0, OP_JP = 4'h1, OP_CALL = 4'h2, OP_SE_K = 4'h3;
    localparam logic [3:0] OP_SNE_K = 4'h4, OP_SE_R = 4'h5, OP_LD_K = 4'h6, OP_ADD_K = 4'h7;
    localparam logic [3:0] OP_ALU = 4'h8, OP_SNE_R = 4'h9, OP_LD_I = 4'hA, OP_JP_V = 4'hB;
    localparam logic [3:0] OP_RND = 4'hC, OP_DRW = 4'hD, OP_KEY = 4'hE, OP_MISC = 4'hF;
    // ALU selectors (low nibble of 8xyN)
    localparam logic [3:0] A_MOV = 4'h0, A_OR = 4'h1, A_AND = 4'h2, A_XOR = 4'h3;
    localparam logic [3:0] A_ADD = 4'h4, A_SUB = 4'h5, A_SHR = 4'h6, A_SUBN = 4'h7;
    localparam logic [3:0] A_SHL = 4'hE;
    // low byte selectors
    localparam logic [7:0] K_CLS = 8'hE0, K_RET = 8'hEE, K_SKP = 8'h9E, K_SKNP = 8'hA1;
    localparam logic [7:0] F_GDT = 8'h07, F_WKEY = 8'h0A, F_SDT = 8'h15, F_SST = 8'h18;
    localparam logic [7:0] F_ADDI = 8'h1E, F_FONT = 8'h29, F_BCD = 8'h33;
    localparam logic [7:0] F_STORE = 8'h55, F_LOAD = 8'h65;
    localparam logic [2:0] CMD_NONE = 3'd7;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [15:0] opcode;
        logic [15:0] keys;
        logic [7:0]  rnd;
        logic [3:0]  kc;
        logic [11:0] addr;
        logic [7:0]  wdata;
    } c8_item_t;

    typedef struct packed {
        logic [11:0] pc;
        logic [15:0] index;
        logic [63:0] rdata;
        logic        waiting;
        logic        sound;
    } c8_result_t;

    typedef struct packed {
        c8_item_t   item;
        logic       fixed;
        c8_result_t res;
    } dir_row_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [1:0] i_cfg_idx = '0;
    logic [0:0] i_cfg_wdata = '0;

    c8_in_if in_ch();
    c8_out_if out_ch();

    chip8_instruction_executor_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch), .o_out(out_ch),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_wdata(i_cfg_wdata)
    );

    always #2 i_clk = ~i_clk;

    // machine state as the block should hold it
    bit [7:0]  mem_img [MEM_BYTES];
    bit [63:0] frame_img [32];
    bit [7:0]  v_regs [16];
    bit [15:0] index_q;
    bit [11:0] pc_q;
    bit [11:0] call_stack [16];
    int        sp_q;
    bit [7:0]  delay_q, sound_q;
    bit        wait_q;
    bit [3:0]  wait_reg;
    bit        cfg_shift_vy, cfg_jump_vx, cfg_block_idx;

    c8_result_t expected_results[$];
    int errors = 0;
    int cycles = 0;
    bit quiet = 1'b0;
    int out_stall = 0;

    function automatic void model_reset();
        foreach (mem_img[a]) mem_img[a] = '0;
        for (int a = 0; a < FONT_BYTES; a++) mem_img[FONT_BASE + a] = FONT[a];
        foreach (frame_img[r]) frame_img[r] = '0;
        foreach (v_regs[r]) v_regs[r] = '0;
        foreach (call_stack[r]) call_stack[r] = '0;
        index_q = '0; pc_q = PC_START; sp_q = 0; delay_q = '0; sound_q = '0;
        wait_q = 1'b0; wait_reg = '0;
        cfg_shift_vy = 1'b0; cfg_jump_vx = 1'b0; cfg_block_idx = 1'b0;
    endfunction

    function automatic void alu_step(bit [3:0] x, bit [3:0] y, bit [3:0] sel);
        bit [7:0] vx, vy, src;
        bit flag;
        vx = v_regs[x];
        vy = v_regs[y];
        case (sel)
            A_MOV: begin v_regs[x] = vy; return; end
            A_OR:  begin v_regs[x] = vx | vy; v_regs[15] = '0; return; end
            A_AND: begin v_regs[x] = vx & vy; v_regs[15] = '0; return; end
            A_XOR: begin v_regs[x] = vx ^ vy; v_regs[15] = '0; return; end
            A_ADD: begin flag = (9'(vx) + 9'(vy)) > 9'd255; v_regs[x] = vx + vy; end
            A_SUB: begin flag = vx >= vy; v_regs[x] = vx - vy; end
            A_SHR: begin
                src = cfg_shift_vy ? vy : vx;
                flag = src[0];
                v_regs[x] = src >> 1;
            end
            A_SUBN: begin flag = vy >= vx; v_regs[x] = vy - vx; end
            A_SHL: begin
                src = cfg_shift_vy ? vy : vx;
                flag = src[7];
                v_regs[x] = src << 1;
            end
            default: return;
        endcase
        v_regs[15] = {7'd0, flag};
    endfunction

    function automatic void sprite_xor(bit [3:0] x, bit [3:0] y, bit [3:0] n);
        int cx, cy, px;
        bit [7:0] bits;
        bit hit;
        cx = v_regs[x] % 64;
        cy = v_regs[y] % 32;
        hit = 1'b0;
        for (int r = 0; r < n; r++) begin
            if (cy + r >= 32) break;
            bits = mem_img[12'(index_q + r)];
            for (int c = 0; c < 8; c++) begin
                px = (cx + c) % 64;
                if (bits[7 - c]) begin
                    if (frame_img[cy + r][63 - px]) hit = 1'b1;
                    frame_img[cy + r][63 - px] ^= 1'b1;
                end
            end
        end
        v_regs[15] = {7'd0, hit};
    endfunction

    function automatic bit [11:0] run_instr(c8_item_t it);
        bit [3:0] x, y, n, grp, key;
        bit [7:0] kk;
        bit [11:0] nnn, step;
        x = it.opcode[11:8]; y = it.opcode[7:4]; n = it.opcode[3:0];
        grp = it.opcode[15:12]; kk = it.opcode[7:0]; nnn = it.opcode[11:0];
        step = 12'd2;
        key = v_regs[x][3:0];
        if (wait_q) return pc_q;
        case (grp)
            OP_SYS: begin
                if (kk == K_CLS) begin
                    foreach (frame_img[r]) frame_img[r] = '0;
                end else if (kk == K_RET && x == 4'h0 && sp_q > 0) begin
                    sp_q--;
                    return call_stack[sp_q % 16];
                end
            end
            OP_JP: return nnn;
            OP_CALL: begin
                if (sp_q < STACK_DEPTH) begin
                    call_stack[sp_q] = pc_q + 12'd2;
                    sp_q++;
                    return nnn;
                end
            end
            OP_SE_K:  if (v_regs[x] == kk) step = 12'd4;
            OP_SNE_K: if (v_regs[x] != kk) step = 12'd4;
            OP_SE_R:  if (n == 4'h0 && v_regs[x] == v_regs[y]) step = 12'd4;
            OP_LD_K:  v_regs[x] = kk;
            OP_ADD_K: v_regs[x] = v_regs[x] + kk;
            OP_ALU:   alu_step(x, y, n);
            OP_SNE_R: if (n == 4'h0 && v_regs[x] != v_regs[y]) step = 12'd4;
            OP_LD_I:  index_q = {4'd0, nnn};
            OP_JP_V:  return nnn + (cfg_jump_vx ? v_regs[x] : v_regs[0]);
            OP_RND:   v_regs[x] = it.rnd & kk;
            OP_DRW:   sprite_xor(x, y, n);
            OP_KEY: begin
                if (kk == K_SKP && it.keys[key]) step = 12'd4;
                if (kk == K_SKNP && !it.keys[key]) step = 12'd4;
            end
            default: begin
                case (kk)
                    F_GDT: v_regs[x] = delay_q;
                    F_WKEY: begin
                        wait_q = 1'b1;
                        wait_reg = x;
                        return pc_q;
                    end
                    F_SDT:  delay_q = v_regs[x];
                    F_SST:  sound_q = v_regs[x];
                    F_ADDI: index_q = index_q + v_regs[x];
                    F_FONT: index_q = 16'(FONT_BASE) + 16'(v_regs[x][3:0]) * 16'd5;
                    F_BCD: begin
                        mem_img[12'(index_q)]     = v_regs[x] / 100;
                        mem_img[12'(index_q + 1)] = (v_regs[x] / 10) % 10;
                        mem_img[12'(index_q + 2)] = v_regs[x] % 10;
                    end
                    F_STORE: begin
                        for (int i = 0; i <= x; i++) mem_img[12'(index_q + i)] = v_regs[i];
                        if (cfg_block_idx) index_q = index_q + x + 16'd1;
                    end
                    F_LOAD: begin
                        for (int i = 0; i <= x; i++) v_regs[i] = mem_img[12'(index_q + i)];
                        if (cfg_block_idx) index_q = index_q + x + 16'd1;
                    end
                    default: ;
                endcase
            end
        endcase
        return pc_q + step;
    endfunction

    function automatic c8_result_t predict_result(c8_item_t it);
        c8_result_t r;
        r.rdata = '0;
        case (it.cmd)
            CMD_EXEC: pc_q = run_instr(it);
            CMD_KEY: begin
                if (wait_q) begin
                    v_regs[wait_reg] = {4'd0, it.kc};
                    wait_q = 1'b0;
                    pc_q = pc_q + 12'd2;
                end
            end
            CMD_TICK: begin
                if (delay_q != 0) delay_q--;
                if (sound_q != 0) sound_q--;
            end
            CMD_MEM_WR: mem_img[it.addr] = it.wdata;
            CMD_MEM_RD: r.rdata = 64'(mem_img[it.addr]);
            CMD_ROW_RD: if (it.addr < 32) r.rdata = frame_img[it.addr];
            CMD_REG_RD: begin
                if (it.addr < 16) r.rdata = 64'(v_regs[it.addr]);
                else if (it.addr == REG_DELAY) r.rdata = 64'(delay_q);
                else if (it.addr == REG_SOUND) r.rdata = 64'(sound_q);
                else if (it.addr == REG_SP) r.rdata = 64'(sp_q);
            end
            default: ;
        endcase
        r.pc = pc_q;
        r.index = index_q;
        r.waiting = wait_q;
        r.sound = sound_q != 0;
        return r;
    endfunction

    function automatic c8_item_t blank_item(bit [2:0] cmd);
        c8_item_t it;
        it.cmd = cmd;
        it.opcode = 16'($urandom);
        it.keys = 16'($urandom);
        it.rnd = 8'($urandom);
        it.kc = 4'($urandom);
        it.addr = 12'($urandom);
        it.wdata = 8'($urandom);
        return it;
    endfunction

    function automatic dir_row_t dir(bit [2:0] cmd, bit [15:0] op, bit [11:0] addr,
                                     bit fixed, bit [63:0] rdata);
        dir_row_t row;
        row.item = '{cmd: cmd, opcode: op, keys: 16'h8001, rnd: 8'hFF, kc: 4'hF,
                     addr: addr, wdata: 8'hA5};
        row.fixed = fixed;
        row.res = '{pc: PC_START, index: 16'd0, rdata: rdata, waiting: 1'b0, sound: 1'b0};
        return row;
    endfunction

    function automatic dir_row_t ex(bit [15:0] op);
        return dir(CMD_EXEC, op, 12'd0, 1'b0, '0);
    endfunction

    function automatic bit [15:0] rand_opcode();
        bit [3:0] grp, x, y, n;
        bit [7:0] kk;
        bit [3:0] alu_sel [9] = '{A_MOV, A_OR, A_AND, A_XOR, A_ADD, A_SUB, A_SHR, A_SUBN,
                                  A_SHL};
        bit [7:0] misc_sel [9] = '{F_GDT, F_WKEY, F_SDT, F_SST, F_ADDI, F_FONT, F_BCD,
                                   F_STORE, F_LOAD};
        grp = 4'($urandom); x = 4'($urandom); y = 4'($urandom); n = 4'($urandom);
        kk = 8'($urandom);
        case (grp)
            OP_SYS: begin
                if ($urandom_range(0, 9) < 5) return {OP_SYS, 4'h0, K_RET};
                if ($urandom_range(0, 9) < 2) return {OP_SYS, 4'h0, K_CLS};
            end
            OP_SE_R, OP_SNE_R: if ($urandom_range(0, 3) != 0) n = 4'h0;
            OP_SE_K, OP_SNE_K: if ($urandom_range(0, 1) == 0) kk = 8'($urandom_range(0, 3));
            OP_ALU: if ($urandom_range(0, 9) != 0) n = alu_sel[$urandom_range(0, 8)];
            OP_KEY: begin
                if ($urandom_range(0, 9) != 0) kk = $urandom_range(0, 1) ? K_SKP : K_SKNP;
            end
            OP_MISC: if ($urandom_range(0, 9) != 0) kk = misc_sel[$urandom_range(0, 8)];
            default: ;
        endcase
        if (grp inside {OP_SE_R, OP_SNE_R, OP_ALU, OP_DRW}) return {grp, x, y, n};
        return {grp, x, kk};
    endfunction

    function automatic c8_item_t rand_item();
        c8_item_t it;
        int pick;
        pick = $urandom_range(0, 99);
        it = blank_item(CMD_EXEC);
        if (wait_q && pick < 60) begin
            it.cmd = CMD_KEY;
            return it;
        end
        if (pick < 68) it.cmd = CMD_EXEC;
        else if (pick < 75) it.cmd = CMD_TICK;
        else if (pick < 81) it.cmd = CMD_MEM_WR;
        else if (pick < 87) it.cmd = CMD_MEM_RD;
        else if (pick < 92) it.cmd = CMD_ROW_RD;
        else if (pick < 98) it.cmd = CMD_REG_RD;
        else if (pick < 99) it.cmd = CMD_KEY;
        else it.cmd = CMD_NONE;
        if (it.cmd == CMD_EXEC) it.opcode = rand_opcode();
        if (it.cmd == CMD_ROW_RD && $urandom_range(0, 7) != 0) begin
            it.addr = 12'($urandom_range(0, 35));
        end
        if (it.cmd == CMD_REG_RD && $urandom_range(0, 7) != 0) begin
            it.addr = 12'($urandom_range(0, 20));
        end
        return it;
    endfunction

    // hold valid until the beat is taken; call at a rising edge
    task automatic send_beat(c8_item_t it, bit fixed, c8_result_t typed);
        c8_result_t r;
        in_ch.valid <= 1'b1;
        in_ch.cmd <= it.cmd;
        in_ch.opcode <= it.opcode;
        in_ch.key_state <= it.keys;
        in_ch.random_byte <= it.rnd;
        in_ch.key_code <= it.kc;
        in_ch.address <= it.addr;
        in_ch.write_data <= it.wdata;
        do @(posedge i_clk); while (!in_ch.ready);
        r = predict_result(it);
        expected_results.push_back(fixed ? typed : r);
    endtask

    // drop valid only when the sender really pauses
    task automatic idle_gap();
        if (!quiet && $urandom_range(0, 5) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_cfg(bit shift_vy, bit jump_vx, bit block_idx);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= CFG_SHIFT_VY; i_cfg_wdata <= shift_vy;
        @(posedge i_clk);
        i_cfg_idx <= CFG_JUMP_VX; i_cfg_wdata <= jump_vx;
        @(posedge i_clk);
        i_cfg_idx <= CFG_BLOCK_IDX; i_cfg_wdata <= block_idx;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cfg_shift_vy = shift_vy; cfg_jump_vx = jump_vx; cfg_block_idx = block_idx;
    endtask

    // result side: random stall bursts, compare each beat with the oldest expectation
    always @(posedge i_clk) begin
        c8_result_t want;
        if (out_ch.valid && out_ch.ready) begin
            if (expected_results.size() == 0) begin
                $error("unexpected result beat: next_pc %h", out_ch.next_pc);
                errors++;
            end else begin
                want = expected_results.pop_front();
                if (out_ch.next_pc !== want.pc) begin
                    $error("next_pc: expected %h, got %h", want.pc, out_ch.next_pc);
                    errors++;
                end
                if (out_ch.index_value !== want.index) begin
                    $error("index_value: expected %h, got %h", want.index, out_ch.index_value);
                    errors++;
                end
                if (out_ch.read_data !== want.rdata) begin
                    $error("read_data: expected %h, got %h", want.rdata, out_ch.read_data);
                    errors++;
                end
                if (out_ch.awaiting_key !== want.waiting) begin
                    $error("awaiting_key: expected %b, got %b", want.waiting,
                           out_ch.awaiting_key);
                    errors++;
                end
                if (out_ch.sound_active !== want.sound) begin
                    $error("sound_active: expected %b, got %b", want.sound,
                           out_ch.sound_active);
                    errors++;
                end
            end
        end
        if (out_stall > 0) begin
            out_stall--;
            out_ch.ready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
            out_stall = $urandom_range(1, 13) - 1;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        dir_row_t dir_rows[$];
        c8_item_t it;
        int per_phase;
        bit [2:0] cfg_sets [PHASES] = '{3'b111, 3'b101, 3'b010, 3'b000};

        in_ch.valid = 1'b0;
        in_ch.cmd = CMD_EXEC;
        in_ch.opcode = '0;
        in_ch.key_state = '0;
        in_ch.random_byte = '0;
        in_ch.key_code = '0;
        in_ch.address = '0;
        in_ch.write_data = '0;
        out_ch.ready = 1'b1;
        model_reset();

        dir_rows = '{
            dir(CMD_REG_RD, 16'd0, 12'd15, 1'b1, 64'd0),
            dir(CMD_MEM_RD, 16'd0, FONT_BASE, 1'b1, 64'hF0),
            dir(CMD_MEM_RD, 16'd0, 12'h09F, 1'b1, 64'h80),
            dir(CMD_ROW_RD, 16'd0, 12'd40, 1'b1, 64'd0),
            dir(CMD_REG_RD, 16'd0, 12'hFFF, 1'b1, 64'd0),
            dir(CMD_NONE, 16'd0, 12'd0, 1'b1, 64'd0),
            dir(CMD_KEY, 16'd0, 12'd0, 1'b1, 64'd0),
            ex({OP_SYS, 4'h0, K_RET}),
            ex({OP_LD_K, 4'hA, 8'hFF}), ex({OP_LD_K, 4'hB, 8'h01}),
            ex({OP_ALU, 4'hA, 4'hB, A_ADD}), ex({OP_ALU, 4'hA, 4'hB, A_SUB}),
            ex({OP_ALU, 4'hB, 4'hA, A_SUBN}), ex({OP_ALU, 4'hF, 4'hB, A_SHL}),
            ex({OP_CALL, 12'h300}), ex({OP_SYS, 4'h0, K_RET}),
            ex({OP_SE_R, 4'hA, 4'hB, 4'h1}), ex({OP_LD_I, 12'hFFE}),
            ex({OP_MISC, 4'hF, F_BCD}), ex({OP_MISC, 4'hB, F_FONT}),
            ex({OP_LD_K, 4'hC, 8'h3E}), ex({OP_LD_K, 4'hD, 8'h1E}),
            ex({OP_DRW, 4'hC, 4'hD, 4'hF}), dir(CMD_ROW_RD, 16'd0, 12'd31, 1'b0, '0),
            ex({OP_MISC, 4'h3, F_WKEY}), ex({OP_LD_K, 4'h3, 8'h00}),
            dir(CMD_KEY, 16'd0, 12'd0, 1'b0, '0),
            ex({OP_MISC, 4'h3, F_SST}), dir(CMD_TICK, 16'd0, 12'd0, 1'b0, '0),
            ex({OP_KEY, 4'h3, K_SKP}), ex({OP_JP_V, 12'hFFF})
        };

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        write_cfg(1'b0, 1'b0, 1'b0);

        foreach (dir_rows[k]) begin
            idle_gap();
            send_beat(dir_rows[k].item, dir_rows[k].fixed, dir_rows[k].res);
        end

        per_phase = RAND_ITEMS / PHASES;
        for (int p = 0; p < PHASES; p++) begin
            wait_drained();
            write_cfg(cfg_sets[p][2], cfg_sets[p][1], cfg_sets[p][0]);
            for (int k = 0; k < per_phase; k++) begin
                if (p == PHASES - 1 && k == per_phase - 200) quiet = 1'b1;
                // let the result side run dry once mid-phase
                if (p == 1 && k == per_phase / 2) wait_drained();
                idle_gap();
                it = rand_item();
                send_beat(it, 1'b0, '0);
            end
        end

        wait_drained();
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

@@ chip8_instruction_executor_top.f @@
hw/rtl/c8_pkg.sv
hw/rtl/c8_in_if.sv
hw/rtl/c8_out_if.sv
hw/rtl/c8_ram.sv
hw/rtl/c8_datapath.sv
hw/rtl/c8_ctrl.sv
hw/rtl/chip8_instruction_executor_top.sv
tb/chip8_instruction_executor_top_tb.sv
